/* rtl/bpk_pkg.sv */
package bpk_pkg;

    localparam int MAX_BITS_DEF = 32;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int QDEPTH       = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [CNT_W-1:0]   bit_count;
        logic [VAL_W-1:0]   field_value;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

/* rtl/msb_first_bit_packer.sv */
// MSB-first bit packer.
// Input channel (push/full): each transfer is a write of the low bit_count bits
// of field_value (count saturated to MAX_BITS) or a flush of the partial byte.
// Output channel (empty/pop): one transfer per completed byte, first written
// bit in bit 7; last marks the final byte caused by an input item.
// A write that completes no byte produces no output; a flush always produces
// exactly one byte, zero-padded, and clears the pending bits.
// Throughput: one input item per cycle while the job queue has room; output
// runs at one byte per cycle while the receiver pops, so a write that completes k
// bytes holds the output serializer for k transfers (up to 4 with MAX_BITS = 32).
// When the output side is idle, an item's first byte is written to the job queue by
// its input transfer and then loaded into the output stage, where empty falls.
// Reset (synchronous, active low) clears the pending bits, the job queue and
// the output stage; empty is high after reset.
// When the receiver stalls, the current byte holds; jobs collect in a
// four-entry queue, and full rises once it is filled.
module msb_first_bit_packer #(
    parameter int MAX_BITS = bpk_pkg::MAX_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  bpk_pkg::t_in_item   i_in_item,
    output logic                empty,
    input  logic                pop,
    output bpk_pkg::t_out_item  o_out_item
);
    import bpk_pkg::*;

    localparam int NB = (MAX_BITS + 7) / 8;
    localparam int DW = 8 * NB;
    localparam int CW = $clog2(NB + 1);

    t_q_stat        q_stat;
    logic           q_wr, q_rd;
    logic [DW-1:0]  wr_data, rd_data;
    logic [CW-1:0]  wr_cnt, rd_cnt;

    assign full = q_stat.full;

    bpk_front #(.MAX_BITS(MAX_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_in_item),
        .i_q_stat (q_stat),
        .o_q_wr   (q_wr),
        .o_q_data (wr_data),
        .o_q_cnt  (wr_cnt)
    );

    bpk_queue #(.DW(DW), .CW(CW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (wr_data),
        .i_cnt   (wr_cnt),
        .i_rd    (q_rd),
        .o_data  (rd_data),
        .o_cnt   (rd_cnt),
        .o_stat  (q_stat)
    );

    bpk_back #(.DW(DW), .CW(CW)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_data (rd_data),
        .i_q_cnt  (rd_cnt),
        .o_q_rd   (q_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_item   (o_out_item)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output not empty after reset");

    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("job queue both empty and full");

    a_load_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !q_stat.empty) |=> !empty)
        else $error("waiting job not loaded into idle output stage");

    a_flush_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_in_item.cmd == CMD_FLUSH) |-> q_wr)
        else $error("flush did not enqueue a byte");

endmodule

/* rtl/bpk_front.sv */
module bpk_front #(
    parameter int MAX_BITS = bpk_pkg::MAX_BITS_DEF,
    localparam int NB = (MAX_BITS + 7) / 8,
    localparam int DW = 8 * NB,
    localparam int CW = $clog2(NB + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bpk_pkg::t_in_item  i_item,
    input  bpk_pkg::t_q_stat   i_q_stat,
    output logic               o_q_wr,
    output logic [DW-1:0]      o_q_data,
    output logic [CW-1:0]      o_q_cnt
);
    import bpk_pkg::*;

    localparam int LW = DW + 8;
    localparam int SW = $clog2(LW + 1);
    localparam logic [CNT_W-1:0] MaxBitsC = CNT_W'(MAX_BITS);

    logic [7:0]        r_partial, n_partial;
    logic [2:0]        r_fill, n_fill;
    logic              accept;
    logic [CNT_W-1:0]  n_sat;
    logic [VAL_W-1:0]  mask;
    logic [VAL_W-1:0]  val_m;
    logic [6:0]        total;
    logic [SW-1:0]     shamt;
    logic [LW-1:0]     base;
    logic [LW-1:0]     word;
    logic [LW-1:0]     rest;
    logic [CW-1:0]     k;

    assign accept = i_push && !i_q_stat.full;

    // saturate the count, keep only the low count bits of the field
    assign n_sat = (i_item.bit_count > MaxBitsC) ? MaxBitsC : i_item.bit_count;
    assign mask  = (n_sat >= CNT_W'(VAL_W)) ? '1
                 : (VAL_W'(1) << n_sat[4:0]) - VAL_W'(1);
    assign val_m = i_item.field_value & mask;

    // pending bits sit left-aligned at the top; append the field right below them
    assign total = 7'(r_fill) + 7'(n_sat);
    assign shamt = SW'(LW) - SW'(total);
    assign base  = {r_partial, (LW-8)'(0)};
    assign word  = base | (LW'(val_m) << shamt);
    assign k     = CW'(total >> 3);
    assign rest  = word << {k, 3'b000};

    always_comb begin
        n_partial = r_partial;
        n_fill    = r_fill;
        o_q_wr    = 1'b0;
        o_q_data  = word[LW-1 -: DW];
        o_q_cnt   = k;
        if (accept) begin
            unique case (i_item.cmd)
                CMD_FLUSH: begin
                    o_q_wr    = 1'b1;
                    o_q_data  = base[LW-1 -: DW];
                    o_q_cnt   = CW'(1);
                    n_partial = 8'h00;
                    n_fill    = 3'd0;
                end
                CMD_WRITE: begin
                    o_q_wr    = (k != '0);
                    n_partial = rest[LW-1 -: 8];
                    n_fill    = total[2:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= 8'h00;
            r_fill    <= 3'd0;
        end else begin
            r_partial <= n_partial;
            r_fill    <= n_fill;
        end
    end

endmodule

/* rtl/bpk_queue.sv */
module bpk_queue #(
    parameter int DW = 32,
    parameter int CW = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  logic [DW-1:0]      i_data,
    input  logic [CW-1:0]      i_cnt,
    input  logic               i_rd,
    output logic [DW-1:0]      o_data,
    output logic [CW-1:0]      o_cnt,
    output bpk_pkg::t_q_stat   o_stat
);
    import bpk_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int FW = $clog2(QDEPTH + 1);

    logic [DW-1:0] r_mem_data [QDEPTH];
    logic [CW-1:0] r_mem_cnt  [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [FW-1:0] r_level;
    logic          do_wr, do_rd;

    assign o_stat.empty = (r_level == '0);
    assign o_stat.full  = (r_level == FW'(QDEPTH));
    assign do_wr = i_wr && !o_stat.full;
    assign do_rd = i_rd && !o_stat.empty;
    assign o_data = r_mem_data[r_rp];
    assign o_cnt  = r_mem_cnt[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem_data[r_wp] <= i_data;
            r_mem_cnt[r_wp]  <= i_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_rd) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_wr && !do_rd) begin
                r_level <= r_level + FW'(1);
            end else if (do_rd && !do_wr) begin
                r_level <= r_level - FW'(1);
            end
        end
    end

endmodule

/* rtl/bpk_back.sv */
module bpk_back #(
    parameter int DW = 32,
    parameter int CW = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpk_pkg::t_q_stat    i_q_stat,
    input  logic [DW-1:0]       i_q_data,
    input  logic [CW-1:0]       i_q_cnt,
    output logic                o_q_rd,
    input  logic                i_pop,
    output logic                o_empty,
    output bpk_pkg::t_out_item  o_item
);
    import bpk_pkg::*;

    logic          r_busy;
    logic [DW-1:0] r_data;
    logic [CW-1:0] r_left;
    logic          take;
    logic          is_last;

    assign is_last = (r_left == CW'(1));
    assign take    = i_pop && r_busy;
    // load the next job when idle or when its final byte leaves this cycle
    assign o_q_rd  = !i_q_stat.empty && (!r_busy || (take && is_last));

    assign o_empty         = !r_busy;
    assign o_item.out_byte = r_data[DW-1 -: BYTE_W];
    assign o_item.last     = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_q_rd) begin
            r_busy <= 1'b1;
        end else if (take && is_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_data <= i_q_data;
            r_left <= i_q_cnt;
        end else if (take) begin
            r_data <= r_data << BYTE_W;
            r_left <= r_left - CW'(1);
        end
    end

endmodule

/* tb/bit_packer_checker.sv */
module bit_packer_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  bpk_pkg::t_in_item  i_in_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  bpk_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_waiting,
    output int                 o_items,
    output int                 o_bytes
);
    timeunit 1ns;
    timeprecision 1ps;
    import bpk_pkg::*;

    // pending bits, left-aligned, and how many of them are valid
    logic [7:0] pend_bits;
    logic [2:0] pend_cnt;
    t_out_item  expected_bytes[$];

    initial begin
        o_fail_count = 0;
        o_waiting    = 0;
        o_items      = 0;
        o_bytes      = 0;
        pend_bits    = '0;
        pend_cnt     = '0;
    end

    task automatic flag_mismatch(input string what);
        o_fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic predict_bytes(input t_in_item it);
        logic [63:0] acc;
        int          n;
        int          total;
        int          nbytes;
        t_out_item   b;
        if (it.cmd == CMD_FLUSH) begin
            b.out_byte = pend_bits;
            b.last     = 1'b1;
            expected_bytes.push_back(b);
            pend_bits = '0;
            pend_cnt  = '0;
        end else begin
            n = (int'(it.bit_count) > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(it.bit_count);
            if (n > 0) begin
                // right-align the pending bits, then append the field below them
                acc    = 64'(pend_bits) >> (8 - int'(pend_cnt));
                acc    = (acc << n) | (64'(it.field_value) & ((64'd1 << n) - 64'd1));
                total  = int'(pend_cnt) + n;
                nbytes = total / 8;
                for (int k = 0; k < nbytes; k++) begin
                    total -= 8;
                    b.out_byte = 8'(acc >> total);
                    b.last     = (k == nbytes - 1);
                    expected_bytes.push_back(b);
                end
                acc &= (64'd1 << total) - 64'd1;
                pend_bits = 8'(acc << (8 - total));
                pend_cnt  = 3'(total);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            pend_bits = '0;
            pend_cnt  = '0;
            expected_bytes.delete();
        end else begin
            // compare before predicting so a stray byte cannot match a new item
            if (i_pop && !i_empty) begin
                if (expected_bytes.size() == 0) begin
                    flag_mismatch($sformatf("byte %02h (last %0b) with none expected",
                                            i_out_item.out_byte, i_out_item.last));
                end else begin
                    want = expected_bytes.pop_front();
                    o_bytes++;
                    if (i_out_item.out_byte !== want.out_byte) begin
                        flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                                i_out_item.out_byte, want.out_byte));
                    end
                    if (i_out_item.last !== want.last) begin
                        flag_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                                i_out_item.last, want.last, want.out_byte));
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_bytes(i_in_item);
                o_items++;
            end
        end
        o_waiting = expected_bytes.size();
    end

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bpk_pkg::*;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  in_item = '0;
    logic      full;
    logic      empty;
    t_out_item out_item;
    logic      calm    = 1'b0;

    int fail_count;
    int waiting;
    int items_done;
    int bytes_done;
    int flush_cnt = 0;
    int sat_cnt   = 0;
    int zero_cnt  = 0;

    always #6 i_clk = ~i_clk;

    msb_first_bit_packer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item)
    );

    bit_packer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_item    (in_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_items      (items_done),
        .o_bytes      (bytes_done)
    );

    // receiver: stall at random except during the calm stretch
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(99) >= 18);
        end
    end

    task automatic send_item(input logic cmd, input int count, input logic [31:0] value);
        t_in_item it;
        it.cmd         = cmd;
        it.bit_count   = CNT_W'(count);
        it.field_value = value;
        if (cmd == CMD_FLUSH) begin
            flush_cnt++;
        end else if (count > MAX_BITS_DEF) begin
            sat_cnt++;
        end else if (count == 0) begin
            zero_cnt++;
        end
        while (!calm && $urandom_range(99) < 18) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_item <= it;
        // hold until the transfer happens
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    initial begin
        int r;
        int cnt;
        logic cmd;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(CMD_WRITE, 0,  32'hFFFF_FFFF);   // zero count on empty state
        send_item(CMD_FLUSH, 0,  32'h0000_0000);   // flush with nothing pending
        send_item(CMD_WRITE, 32, 32'hFFFF_FFFF);   // full field, four bytes
        send_item(CMD_WRITE, 32, 32'h0000_0000);
        send_item(CMD_WRITE, 1,  32'hFFFF_FFFF);
        send_item(CMD_WRITE, 32, 32'hA5C3_0F96);   // full field on top of one pending bit
        send_item(CMD_WRITE, 0,  32'h1234_5678);   // zero count with bits pending
        send_item(CMD_WRITE, 63, 32'h8000_0001);   // count saturates
        send_item(CMD_WRITE, 33, 32'h1234_5678);
        send_item(CMD_FLUSH, 63, 32'hFFFF_FFFF);   // flush ignores its fields
        send_item(CMD_WRITE, 7,  32'h0000_007F);
        send_item(CMD_FLUSH, 0,  32'h0000_0000);   // padded partial byte
        send_item(CMD_WRITE, 8,  32'hDEAD_BE5A);
        send_item(CMD_WRITE, 3,  32'h0000_0005);
        send_item(CMD_WRITE, 5,  32'hFFFF_FFE6);
        send_item(CMD_WRITE, 31, 32'h7FFF_FFFF);
        send_item(CMD_WRITE, 17, 32'h0001_2345);
        send_item(CMD_FLUSH, 21, 32'h5555_AAAA);
        send_item(CMD_FLUSH, 42, 32'hAAAA_5555);   // back-to-back flushes
        send_item(CMD_WRITE, 1,  32'h0000_0000);
        send_item(CMD_WRITE, 62, 32'hC0DE_F00D);

        for (int i = 0; i < 400; i++) begin
            calm <= (i >= 150 && i < 250);
            cmd = ($urandom_range(99) < 14) ? CMD_FLUSH : CMD_WRITE;
            r   = $urandom_range(99);
            if (r < 8) begin
                cnt = 0;
            end else if (r < 62) begin
                cnt = $urandom_range(12, 1);
            end else if (r < 90) begin
                cnt = $urandom_range(32, 13);
            end else begin
                cnt = $urandom_range(63, 33);
            end
            send_item(cmd, cnt, $urandom);
        end
        push <= 1'b0;
        calm <= 1'b0;

        wait (waiting == 0);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d items: %0d flushes, %0d saturated counts, %0d zero counts.",
                 items_done, flush_cnt, sat_cnt, zero_cnt);
        $display("Checked %0d output bytes under random gaps on both channels.", bytes_done);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d bytes still due.", waiting);
        $display("== FAIL ==");
        $finish;
    end

endmodule
